@@ rtl/core/rloc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the record layout offset calculator: field widths, layout
// constants and configuration register indexes. No dependencies.
package rloc_pkg;

   localparam int OFFSET_BITS_DEFAULT = 24;

   localparam int SIZE_W  = 16;
   localparam int ALIGN_W = 7;
   localparam int BITW_W  = 7;
   localparam int OUT_W   = 24;
   localparam int BITOFF_W = 7;
   localparam int USED_W  = 8;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   localparam int HEADER_BYTES  = 8;
   localparam int MAX_UNIT_BITS = 128;
   localparam int MAX_UNIT_BYTES = MAX_UNIT_BITS / 8;
   localparam int MAX_FRESH_ALIGN = 8;

   localparam logic [0:0] CSR_PACKED_MODE    = 1'b0;
   localparam logic [0:0] CSR_EXPLICIT_ALIGN = 1'b1;

endpackage

@@ rtl/core/record_layout_offset_calculator.sv @@
`timescale 1ns / 1ps
// Record layout offset calculator: lays out one record field per request
// behind an 8-byte header. Depends on rloc_pkg.
//
// Pipeline: an input register, then a result register. Throughput: one request
// per cycle unless a pending result is stalled by rsp_tready low; the record state
// is updated in the single pass between the two registers. Reset (synchronous,
// active high) clears the configuration registers, both valid flags and the record state.
module record_layout_offset_calculator #(
   parameter int OFFSET_BITS = rloc_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // field_size [15:0], field_align [22:16], bit_width [29:23], zero fill
   input  logic [rloc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // byte_offset [23:0], bit_offset [30:24], total_size [54:31], zero fill
   output logic [rloc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // overflow [0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_addr,
   input  logic [rloc_pkg::ALIGN_W-1:0]    csr_wdata
);

   localparam int OB = OFFSET_BITS;
   localparam int SW = rloc_pkg::SIZE_W;
   localparam int AW = rloc_pkg::ALIGN_W;
   localparam int UW = rloc_pkg::USED_W;
   localparam int OW = rloc_pkg::OUT_W;

   function automatic logic [OB:0] align_up_f(input logic [OB-1:0] v,
                                              input logic [AW-1:0] a);
      logic [AW-1:0] am;
      logic [OB:0]   s;
      am = (a == '0) ? '0 : a - AW'(1);
      s  = {1'b0, v} + {{(OB+1-AW){1'b0}}, am};
      return s & ~{{(OB+1-AW){1'b0}}, am};
   endfunction

   function automatic logic [OW-1:0] to_out_f(input logic [OB-1:0] v);
      logic [OB+OW-1:0] t;
      t = {{OW{1'b0}}, v};
      return t[OW-1:0];
   endfunction

   // Configuration registers
   logic          packed_ff, packed_in;
   logic [AW-1:0] expl_align_ff, expl_align_in;

   // Input register
   logic          in_valid_ff, in_valid_in;
   logic [SW-1:0] in_size_ff;
   logic [AW-1:0] in_align_ff;
   logic [AW-1:0] in_bitw_ff;
   logic          in_last_ff;

   // Record state
   logic [OB-1:0] run_off_ff, run_off_in;
   logic [AW-1:0] rec_align_ff, rec_align_in;
   logic [OB-1:0] unit_off_ff, unit_off_in;
   logic [UW-1:0] unit_used_ff, unit_used_in;
   logic [SW-1:0] unit_size_ff, unit_size_in;
   logic          ovf_seen_ff, ovf_seen_in;

   // Result register
   logic                       out_valid_ff, out_valid_in;
   logic [OW-1:0]              out_byte_off_ff;
   logic [rloc_pkg::BITOFF_W-1:0] out_bit_off_ff;
   logic [OW-1:0]              out_total_ff;
   logic                       out_ovf_ff;
   logic                       out_last_ff;

   logic                       advance;
   logic                       step;
   logic                       is_bitfield;
   logic [AW-1:0]              fa;
   logic [AW-1:0]              fa_fresh;
   logic [UW-1:0]              unit_bits;
   logic [UW:0]                bits_need;
   logic                       fresh;
   logic                       do_align;
   logic [AW-1:0]              align_a;
   logic [OB:0]                aligned;
   logic [OB-1:0]              off_a;
   logic                       ovf_a;
   logic [OB:0]                off_sum;
   logic                       add_en;
   logic [OB-1:0]              off_b;
   logic                       ovf_b;
   logic [AW-1:0]              fin_align;
   logic [OB:0]                tot_aligned;
   logic [OB-1:0]              tot_val;
   logic                       ovf_c;
   logic                       ovf_all;
   logic [OB-1:0]              byte_off;
   logic [rloc_pkg::BITOFF_W-1:0] bit_off;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   always_comb begin
      packed_in     = packed_ff;
      expl_align_in = expl_align_ff;
      if (csr_we) begin
         case (csr_addr)
            rloc_pkg::CSR_PACKED_MODE: begin
               packed_in = csr_wdata[0];
            end
            rloc_pkg::CSR_EXPLICIT_ALIGN: begin
               expl_align_in = csr_wdata;
            end
            default: begin
               packed_in = packed_ff;
            end
         endcase
      end
   end

   always_comb begin
      is_bitfield = in_bitw_ff != '0;
      fa          = packed_ff ? AW'(1) : in_align_ff;
      fa_fresh    = (fa < AW'(rloc_pkg::MAX_FRESH_ALIGN)) ? fa
                                                          : AW'(rloc_pkg::MAX_FRESH_ALIGN);
      unit_bits   = (in_size_ff >= SW'(rloc_pkg::MAX_UNIT_BYTES))
                    ? UW'(rloc_pkg::MAX_UNIT_BITS) : {1'b0, in_size_ff[3:0], 3'b000};
      bits_need   = {1'b0, unit_used_ff} + {{(UW+1-AW){1'b0}}, in_bitw_ff};
      fresh       = (unit_size_ff == '0) || (unit_size_ff != in_size_ff) ||
                    (bits_need > {1'b0, unit_bits});

      do_align = !packed_ff && (!is_bitfield || (fresh && unit_size_ff == '0));
      align_a  = is_bitfield ? fa_fresh : fa;
      aligned  = align_up_f(run_off_ff, align_a);
      off_a    = do_align ? aligned[OB-1:0] : run_off_ff;
      ovf_a    = do_align && aligned[OB];

      add_en  = !is_bitfield || fresh;
      off_sum = {1'b0, off_a} + {{(OB+1-SW){1'b0}}, in_size_ff};
      off_b   = add_en ? off_sum[OB-1:0] : off_a;
      ovf_b   = add_en && off_sum[OB];

      rec_align_in = (!is_bitfield && fa > rec_align_ff) ? fa : rec_align_ff;
      unit_off_in  = (is_bitfield && fresh) ? off_a : unit_off_ff;
      unit_size_in = is_bitfield ? in_size_ff : '0;
      if (!is_bitfield) begin
         unit_used_in = '0;
      end else if (fresh) begin
         unit_used_in = {{(UW-AW){1'b0}}, in_bitw_ff};
      end else begin
         unit_used_in = bits_need[UW-1:0];
      end

      byte_off = (is_bitfield && !fresh) ? unit_off_ff : off_a;
      bit_off  = (is_bitfield && !fresh) ? unit_used_ff[rloc_pkg::BITOFF_W-1:0] : '0;

      fin_align   = (expl_align_ff != '0) ? expl_align_ff : rec_align_in;
      tot_aligned = align_up_f(off_b, fin_align);
      tot_val     = packed_ff ? off_b : tot_aligned[OB-1:0];
      ovf_c       = in_last_ff && !packed_ff && tot_aligned[OB];
      ovf_all     = ovf_seen_ff || ovf_a || ovf_b || ovf_c;

      run_off_in  = off_b;
      ovf_seen_in = ovf_all;
      if (in_last_ff) begin
         run_off_in   = OB'(rloc_pkg::HEADER_BYTES);
         rec_align_in = AW'(1);
         unit_off_in  = '0;
         unit_used_in = '0;
         unit_size_in = '0;
         ovf_seen_in  = 1'b0;
      end

      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packed_ff     <= 1'b0;
         expl_align_ff <= '0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         run_off_ff    <= OB'(rloc_pkg::HEADER_BYTES);
         rec_align_ff  <= AW'(1);
         unit_off_ff   <= '0;
         unit_used_ff  <= '0;
         unit_size_ff  <= '0;
         ovf_seen_ff   <= 1'b0;
      end else begin
         packed_ff     <= packed_in;
         expl_align_ff <= expl_align_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         if (step) begin
            run_off_ff   <= run_off_in;
            rec_align_ff <= rec_align_in;
            unit_off_ff  <= unit_off_in;
            unit_used_ff <= unit_used_in;
            unit_size_ff <= unit_size_in;
            ovf_seen_ff  <= ovf_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_size_ff  <= req_tdata[15:0];
         in_align_ff <= req_tdata[22:16];
         in_bitw_ff  <= req_tdata[29:23];
         in_last_ff  <= req_tlast;
      end
      if (step) begin
         out_byte_off_ff <= to_out_f(byte_off);
         out_bit_off_ff  <= bit_off;
         out_total_ff    <= in_last_ff ? to_out_f(tot_val) : '0;
         out_ovf_ff      <= ovf_all;
         out_last_ff     <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_total_ff, out_bit_off_ff, out_byte_off_ff};
   assign rsp_tuser  = out_ovf_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
